// ----- rtl/pst_pkg.sv -----
`default_nettype none

package pst_pkg;

  // Default table size and the fixed field widths of the channels.
  localparam int SLOT_COUNT_DEF = 8;
  localparam int ACT_W          = 3;
  localparam int PRIO_W         = 8;
  localparam int ID_W           = 16;
  localparam int TIME_W         = 32;
  localparam int SIDX_W         = 3;
  localparam int STAT_W         = 2;
  localparam int OSLOT_W        = 3;
  localparam int CNT_W          = 4;

  // Priority that any eligible thread beats or ties.
  localparam logic [PRIO_W-1:0] PRIO_MAX = 8'd255;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_KILL  = 3'd2,
    ACT_SLEEP = 3'd3,
    ACT_SCHED = 3'd4,
    ACT_BLOCK = 3'd5
  } pst_action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_NO_THREAD = 2'd2
  } pst_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESULT
  } pst_state_t;

  // Request as broadcast to every cell during a walk.
  typedef struct packed {
    pst_action_t         action;
    logic [PRIO_W-1:0]   prio;
    logic [ID_W-1:0]     ident;
    logic [TIME_W-1:0]   tick_time;
    logic [TIME_W-1:0]   wake_time;
    logic [SIDX_W-1:0]   slot_index;
    logic                blocked_flag;
    logic                room;
  } pst_req_t;

  // Running summary handed from one cell to the next.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] best_prio;
    logic              found;
    logic              placed;
    logic              any_hit;
    logic              ge_hit;
  } pst_carry_t;

endpackage

`default_nettype wire

// ----- rtl/pst_in_if.sv -----
`default_nettype none

interface pst_in_if;
  logic                        valid;
  logic                        ready;
  logic [pst_pkg::ACT_W-1:0]   action;
  logic [pst_pkg::PRIO_W-1:0]  prio_value;
  logic [pst_pkg::ID_W-1:0]    thread_ident;
  logic [pst_pkg::TIME_W-1:0]  sleep_ticks;
  logic [pst_pkg::SIDX_W-1:0]  slot_index;
  logic                        blocked_flag;

  modport source (
    output valid, action, prio_value, thread_ident, sleep_ticks, slot_index, blocked_flag,
    input  ready
  );

  modport sink (
    input  valid, action, prio_value, thread_ident, sleep_ticks, slot_index, blocked_flag,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/pst_out_if.sv -----
`default_nettype none

interface pst_out_if;
  logic                         valid;
  logic                         ready;
  logic [pst_pkg::STAT_W-1:0]   status;
  logic [pst_pkg::OSLOT_W-1:0]  running_slot;
  logic [pst_pkg::ID_W-1:0]     running_ident;
  logic [pst_pkg::CNT_W-1:0]    live_count;

  modport source (
    output valid, status, running_slot, running_ident, live_count,
    input  ready
  );

  modport sink (
    input  valid, status, running_slot, running_ident, live_count,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/priority_thread_scheduler.sv -----
// Priority thread scheduler: a table of SLOT_COUNT thread slots, one per cell in a chain,
// serving tick, add, kill, sleep, schedule and set-blocked requests, one result per request.
// A request is broadcast to all cells and a summary token walks the chain one cell per
// cycle; each request goes through launch, one step per cell, commit of add, kill and
// schedule, and result load before the next request is taken; the result load waits
// while the output register holds an unaccepted result. The next request is taken
// while a finished result still waits in the output register. Schedule picks the eligible
// thread with the lowest priority value, the highest slot on a tie, or slot 0 when none
// is eligible; running_ident reads 0 when the running slot holds no live thread.

`default_nettype none

module priority_thread_scheduler #(
  parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pst_in_if.sink     in_chan,
  pst_out_if.source  out_chan
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int TW = $clog2(SLOT_COUNT + 1);

  pst_pkg::pst_state_t state_r, state_nxt;
  pst_pkg::pst_req_t   req_r, req_nxt;
  pst_pkg::pst_status_t status_r, status_nxt;
  pst_pkg::pst_status_t out_status_r;

  logic                        launch_r;
  logic [pst_pkg::TIME_W-1:0]  tick_time_r;
  logic [TW-1:0]               total_r, total_nxt;
  logic [IW-1:0]               cur_r, cur_nxt;
  logic                        out_valid_r;
  logic [pst_pkg::OSLOT_W-1:0] out_slot_r;
  logic [pst_pkg::ID_W-1:0]    out_ident_r;
  logic [pst_pkg::CNT_W-1:0]   out_count_r;

  logic in_ready;
  logic accept;
  logic commit;
  logic load_out;

  pst_pkg::pst_carry_t         chain   [SLOT_COUNT+1];
  logic [IW-1:0]               best_c  [SLOT_COUNT+1];
  logic [IW-1:0]               any_c   [SLOT_COUNT+1];
  logic [IW-1:0]               ge_c    [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0]       alive_vec;
  logic [pst_pkg::ID_W-1:0]    ident_arr [SLOT_COUNT];

  pst_pkg::pst_carry_t tail;
  logic [IW-1:0]       kill_target;
  logic                kill_ok;
  logic                free_en;
  logic [pst_pkg::ID_W-1:0] run_ident;
  logic [IW+2:0]       slot_ext;
  logic [TW+3:0]       count_ext;

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pst_pkg::S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = pst_pkg::S_WALK;
        end
      end
      pst_pkg::S_WALK: begin
        if (tail.valid) begin
          state_nxt = pst_pkg::S_RESULT;
        end
      end
      pst_pkg::S_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = pst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pst_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    load_out = 1'b0;
    case (state_r)
      pst_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      pst_pkg::S_WALK: begin
        commit = tail.valid;
      end
      pst_pkg::S_RESULT: begin
        load_out = !out_valid_r || out_chan.ready;
      end
      default: begin
      end
    endcase
  end

  assign accept = in_chan.valid && in_ready;

  // Request capture; the tick advance and the wake time are worked out here.
  always_comb begin
    req_nxt.action       = pst_pkg::pst_action_t'(in_chan.action);
    req_nxt.prio         = in_chan.prio_value;
    req_nxt.ident        = in_chan.thread_ident;
    req_nxt.tick_time    = (req_nxt.action == pst_pkg::ACT_TICK) ?
                           tick_time_r + pst_pkg::TIME_W'(1) : tick_time_r;
    req_nxt.wake_time    = tick_time_r + in_chan.sleep_ticks;
    req_nxt.slot_index   = in_chan.slot_index;
    req_nxt.blocked_flag = in_chan.blocked_flag;
    req_nxt.room         = (total_r < TW'(SLOT_COUNT));
  end

  // Token entering the head of the chain.
  always_comb begin
    chain[0].valid     = launch_r;
    chain[0].best_prio = pst_pkg::PRIO_MAX;
    chain[0].found     = 1'b0;
    chain[0].placed    = 1'b0;
    chain[0].any_hit   = 1'b0;
    chain[0].ge_hit    = 1'b0;
    best_c[0]          = '0;
    any_c[0]           = '0;
    ge_c[0]            = '0;
  end

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    pst_cell #(
      .SLOT_COUNT (SLOT_COUNT),
      .INDEX      (i),
      .IW         (IW)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .req           (req_r),
      .cur_slot      (cur_r),
      .kill_target   (kill_target),
      .free_en       (free_en),
      .cin           (chain[i]),
      .cin_best_idx  (best_c[i]),
      .cin_any_idx   (any_c[i]),
      .cin_ge_idx    (ge_c[i]),
      .cout          (chain[i+1]),
      .cout_best_idx (best_c[i+1]),
      .cout_any_idx  (any_c[i+1]),
      .cout_ge_idx   (ge_c[i+1]),
      .alive         (alive_vec[i]),
      .ident         (ident_arr[i])
    );
  end

  assign tail = chain[SLOT_COUNT];

  // Commit: kill target search wraps from the running slot, then count and slot update.
  always_comb begin
    kill_target = tail.ge_hit ? ge_c[SLOT_COUNT] : any_c[SLOT_COUNT];
    kill_ok     = tail.any_hit && (total_r > TW'(1));
    free_en     = commit && (req_r.action == pst_pkg::ACT_KILL) && kill_ok;
    total_nxt   = total_r;
    cur_nxt     = cur_r;
    status_nxt  = pst_pkg::ST_OK;
    case (req_r.action)
      pst_pkg::ACT_ADD: begin
        if (tail.placed) begin
          total_nxt = total_r + TW'(1);
        end else begin
          status_nxt = pst_pkg::ST_LIMIT;
        end
      end
      pst_pkg::ACT_KILL: begin
        if (!tail.any_hit) begin
          status_nxt = pst_pkg::ST_NO_THREAD;
        end else if (kill_ok) begin
          total_nxt = total_r - TW'(1);
        end
      end
      pst_pkg::ACT_SCHED: begin
        cur_nxt = tail.found ? best_c[SLOT_COUNT] : '0;
      end
      default: begin
      end
    endcase
  end

  // Result fields, read from the running slot's cell.
  assign run_ident = alive_vec[cur_r] ? ident_arr[cur_r] : '0;
  assign slot_ext  = {3'b000, cur_r};
  assign count_ext = {4'b0000, total_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pst_pkg::S_IDLE;
      launch_r    <= 1'b0;
      tick_time_r <= '0;
      total_r     <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= accept;
      if (accept) begin
        tick_time_r <= req_nxt.tick_time;
      end
      if (commit) begin
        total_r <= total_nxt;
        cur_r   <= cur_nxt;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_nxt;
    end
    if (commit) begin
      status_r <= status_nxt;
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_slot_r   <= slot_ext[pst_pkg::OSLOT_W-1:0];
      out_ident_r  <= run_ident;
      out_count_r  <= count_ext[pst_pkg::CNT_W-1:0];
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.running_slot  = out_slot_r;
  assign out_chan.running_ident = out_ident_r;
  assign out_chan.live_count    = out_count_r;

  // Outside a walk the live count matches the number of alive cells; an add claims its
  // cell during the walk, before the count moves at commit.
  a_total_matches_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pst_pkg::S_WALK) |-> ($countones(alive_vec) == int'(total_r)))
    else $error("live count differs from alive slots");

  // The live count never exceeds the table size.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(total_r) <= SLOT_COUNT)
    else $error("live count above slot count");

  // The running slot always names a slot of the table.
  a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cur_r) < SLOT_COUNT)
    else $error("running slot out of range");

  // The token leaves the chain only while a walk is in progress.
  a_tail_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (state_r == pst_pkg::S_WALK))
    else $error("chain token outside a walk");

  // A placed add raises the live count by one.
  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && (req_r.action == pst_pkg::ACT_ADD) && tail.placed) |=>
    (int'(total_r) == int'($past(total_r)) + 1))
    else $error("add did not raise live count");

endmodule

`default_nettype wire

// ----- rtl/pst_cell.sv -----
`default_nettype none

module pst_cell #(
  parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEF,
  parameter int INDEX      = 0,
  parameter int IW         = $clog2(SLOT_COUNT)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pst_pkg::pst_req_t            req,
  input  wire logic [IW-1:0]                cur_slot,
  input  wire logic [IW-1:0]                kill_target,
  input  wire logic                         free_en,
  input  wire pst_pkg::pst_carry_t          cin,
  input  wire logic [IW-1:0]                cin_best_idx,
  input  wire logic [IW-1:0]                cin_any_idx,
  input  wire logic [IW-1:0]                cin_ge_idx,
  output pst_pkg::pst_carry_t               cout,
  output logic [IW-1:0]                     cout_best_idx,
  output logic [IW-1:0]                     cout_any_idx,
  output logic [IW-1:0]                     cout_ge_idx,
  output logic                              alive,
  output logic [pst_pkg::ID_W-1:0]          ident
);

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
  localparam bit BLK_REACH = (INDEX < (1 << pst_pkg::SIDX_W));

  logic [pst_pkg::PRIO_W-1:0] prio_r;
  logic [pst_pkg::ID_W-1:0]   ident_r;
  logic [pst_pkg::TIME_W-1:0] wake_r;
  logic                       alive_r, alive_nxt;
  logic                       blocked_r, blocked_nxt;
  logic                       asleep_r, asleep_nxt;
  pst_pkg::pst_carry_t        cout_r, cout_nxt;
  logic [IW-1:0]              best_idx_r, best_idx_nxt;
  logic [IW-1:0]              any_idx_r, any_idx_nxt;
  logic [IW-1:0]              ge_idx_r, ge_idx_nxt;

  logic go;
  logic is_cur;
  logic blk_hit;
  logic claim;
  logic eligible;
  logic take;
  logic id_hit;

  // The request reaches this cell when the carry from its left neighbor is valid.
  assign go       = cin.valid;
  assign is_cur   = (cur_slot == MY_IDX);
  assign blk_hit  = BLK_REACH && (req.slot_index == pst_pkg::SIDX_W'(INDEX));
  assign claim    = go && (req.action == pst_pkg::ACT_ADD) && req.room &&
                    !cin.placed && !alive_r;
  assign eligible = alive_r && !blocked_r && !asleep_r;
  assign take     = go && (req.action == pst_pkg::ACT_SCHED) && eligible &&
                    (prio_r <= cin.best_prio);
  assign id_hit   = alive_r && (ident_r == req.ident);

  // Slot flags: updated by the passing request or by a kill at commit.
  always_comb begin
    alive_nxt   = alive_r;
    blocked_nxt = blocked_r;
    asleep_nxt  = asleep_r;
    if (go) begin
      case (req.action)
        pst_pkg::ACT_TICK: begin
          if (asleep_r && (req.tick_time >= wake_r)) begin
            asleep_nxt = 1'b0;
          end
        end
        pst_pkg::ACT_ADD: begin
          if (claim) begin
            alive_nxt   = 1'b1;
            blocked_nxt = 1'b0;
            asleep_nxt  = 1'b0;
          end
        end
        pst_pkg::ACT_SLEEP: begin
          if (is_cur) begin
            asleep_nxt = 1'b1;
          end
        end
        pst_pkg::ACT_BLOCK: begin
          if (blk_hit) begin
            blocked_nxt = req.blocked_flag;
          end
        end
        default: begin
        end
      endcase
    end
    if (free_en && (kill_target == MY_IDX)) begin
      alive_nxt   = 1'b0;
      blocked_nxt = 1'b0;
      asleep_nxt  = 1'b0;
    end
  end

  // Summary handed on: best schedule candidate, add placement, kill matches.
  always_comb begin
    cout_nxt       = cin;
    cout_nxt.valid = go;
    best_idx_nxt   = cin_best_idx;
    any_idx_nxt    = cin_any_idx;
    ge_idx_nxt     = cin_ge_idx;
    if (take) begin
      cout_nxt.best_prio = prio_r;
      cout_nxt.found     = 1'b1;
      best_idx_nxt       = MY_IDX;
    end
    if (claim) begin
      cout_nxt.placed = 1'b1;
    end
    if (id_hit && !cin.any_hit) begin
      cout_nxt.any_hit = 1'b1;
      any_idx_nxt      = MY_IDX;
    end
    if (id_hit && !cin.ge_hit && (MY_IDX >= cur_slot)) begin
      cout_nxt.ge_hit = 1'b1;
      ge_idx_nxt      = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r   <= 1'b0;
      blocked_r <= 1'b0;
      asleep_r  <= 1'b0;
      cout_r    <= '0;
    end else begin
      alive_r   <= alive_nxt;
      blocked_r <= blocked_nxt;
      asleep_r  <= asleep_nxt;
      cout_r    <= cout_nxt;
    end
  end

  // Slot payload and carried indexes need no reset.
  always_ff @(posedge clk) begin
    if (claim) begin
      prio_r  <= req.prio;
      ident_r <= req.ident;
    end
    if (go && (req.action == pst_pkg::ACT_SLEEP) && is_cur) begin
      wake_r <= req.wake_time;
    end
    if (go) begin
      best_idx_r <= best_idx_nxt;
      any_idx_r  <= any_idx_nxt;
      ge_idx_r   <= ge_idx_nxt;
    end
  end

  assign cout          = cout_r;
  assign cout_best_idx = best_idx_r;
  assign cout_any_idx  = any_idx_r;
  assign cout_ge_idx   = ge_idx_r;
  assign alive         = alive_r;
  assign ident         = ident_r;

endmodule

`default_nettype wire
